FILE: rtl/core/mctw_pkg.sv
// ----------------------------------------------------------------------------
// mctw_pkg
// Shared types and constants of the multi-channel task watchdog.
// ----------------------------------------------------------------------------
package mctw_pkg;

    localparam int CHANNELS      = 8;
    localparam int TICK_SECONDS  = 5;
    localparam int START_SECONDS = 15;

    localparam int COUNT_W   = 14;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Reciprocal of the tick period, rounded up, scaled by 2^32; exact
    // for any 16-bit dividend since the rounding error stays below 1/T.
    localparam int          RECIP_SHIFT = 32;
    localparam int          RECIP_W     = 33;
    localparam logic [63:0] RECIP_64    = ((64'd1 << RECIP_SHIFT) + 64'(TICK_SECONDS) - 64'd1)
                                          / 64'(TICK_SECONDS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_64[RECIP_W-1:0];
    localparam int PROD_W = 16 + RECIP_W;
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;

    localparam int START_RAW   = START_SECONDS / TICK_SECONDS;
    localparam int START_SAT   = (START_RAW > COUNT_MAX) ? COUNT_MAX : START_RAW;
    localparam logic [COUNT_W-1:0] START_TICKS = COUNT_W'(START_SAT);

    localparam logic ACT_KICK = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic        action;
        logic [2:0]  channel;
        logic [15:0] timeout_secs;
    } t_item;

    typedef struct packed {
        logic               expired_now;
        logic [2:0]         expired_channel;
        logic               tripped;
        logic [COUNT_W-1:0] channel_count;
    } t_result;

    typedef struct packed {
        logic capture;
        logic mult;
        logic update;
    } t_cmd;

endpackage

FILE: rtl/core/multi_channel_task_watchdog_core.sv
// ----------------------------------------------------------------------------
// multi_channel_task_watchdog_core
// Per-channel tick countdowns with kick reload, tick decrement and a sticky
// trip flag that freezes the block until reset.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Beat contents
//  ---------+----------------------+------------------------------------------
//  command  | i_start / o_busy     | i_item: action, channel, timeout_secs
//  result   | o_valid (1 cycle)    | o_result: expired_now, expired_channel,
//           |                      |           tripped, channel_count
//
//  Each command beat goes through capture, the reciprocal multiply that
//  turns seconds into ticks, and the counter commit, in that order. The result beat shows
//  on the cycle after the commit, when o_busy is already low again, so a new
//  command may be accepted in the same cycle that the result is presented.
//  Reset loads every channel with the start count and clears the trip flag.
//  The receiver cannot stall; o_valid is a one-cycle strobe.
//
module multi_channel_task_watchdog_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  mctw_pkg::t_item   i_item,
    output logic              o_valid,
    output mctw_pkg::t_result o_result
);
    import mctw_pkg::*;

    t_cmd cmd;

    // Sequencer: advance capture -> multiply -> commit per accepted beat.
    mctw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // Datapath: counters, trip latch, and the registered result beat.
    mctw_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

FILE: rtl/core/mctw_ctrl.sv
// ----------------------------------------------------------------------------
// mctw_ctrl
// Sequencer: capture the item, run the divide multiply, then commit.
// ----------------------------------------------------------------------------
module mctw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_valid,
    output mctw_pkg::t_cmd o_cmd
);
    import mctw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_MUL;
                    n_busy  = 1'b1;
                end
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
                n_valid = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    assign o_cmd.capture = (r_state == ST_IDLE) && i_start;
    assign o_cmd.mult    = (r_state == ST_MUL);
    assign o_cmd.update  = (r_state == ST_UPD);
    assign o_busy        = r_busy;
    assign o_valid       = r_valid;

endmodule

FILE: rtl/core/mctw_dp.sv
// ----------------------------------------------------------------------------
// mctw_dp
// Channel counters, trip latch, timeout-to-ticks conversion and result reg.
// ----------------------------------------------------------------------------
module mctw_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mctw_pkg::t_cmd    i_cmd,
    input  mctw_pkg::t_item   i_item,
    output mctw_pkg::t_result o_result
);
    import mctw_pkg::*;

    t_item              r_item;
    logic [PROD_W-1:0]  r_prod;
    logic [COUNT_W-1:0] r_count [CHANNELS];
    logic [COUNT_W-1:0] n_count [CHANNELS];
    logic               r_trip;
    t_result            r_result, n_result;

    logic [QUOT_W-1:0]  quot_raw;
    logic [COUNT_W-1:0] quot;
    logic [CH_W-1:0]    idx;
    logic               in_range;
    logic               hit;
    logic [CH_W-1:0]    first;

    assign quot_raw = r_prod[PROD_W-1:RECIP_SHIFT];
    assign quot     = (quot_raw > QUOT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                      : quot_raw[COUNT_W-1:0];
    assign idx      = CH_W'(r_item.channel);
    assign in_range = (32'(r_item.channel) < CHANNELS);

    always_comb begin
        n_count = r_count;
        hit     = 1'b0;
        first   = '0;
        if (!r_trip) begin
            if (r_item.action == ACT_KICK) begin
                if (in_range) begin
                    n_count[idx] = quot;
                end
            end else begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_count[i] <= COUNT_W'(1)) begin
                        if (!hit) begin
                            hit   = 1'b1;
                            first = CH_W'(i);
                        end
                        n_count[i] = '0;
                    end else begin
                        n_count[i] = r_count[i] - COUNT_W'(1);
                    end
                end
            end
        end
        n_result.expired_now     = hit;
        n_result.expired_channel = 3'(first);
        n_result.tripped         = r_trip | hit;
        n_result.channel_count   = in_range ? n_count[idx] : '0;
    end

    // Payload registers: hold item, product and result without reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.mult) begin
            r_prod <= PROD_W'(r_item.timeout_secs) * PROD_W'(RECIP);
        end
        if (i_cmd.update) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trip <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i] <= START_TICKS;
            end
        end else if (i_cmd.update) begin
            r_trip  <= r_trip | hit;
            r_count <= n_count;
        end
    end

    assign o_result = r_result;

endmodule

FILE: sim/multi_channel_task_watchdog_core_tb.sv
// ----------------------------------------------------------------------------
// multi_channel_task_watchdog_core_tb
// Drives kick and tick beats into the watchdog core and checks every result
// beat field by field. A local model of the per-channel countdowns and the
// trip flag predicts each result. The counters stay alive through the
// directed and random traffic, and the single expiry is forced at the end,
// followed by beats that must find the block frozen.
// ----------------------------------------------------------------------------
module multi_channel_task_watchdog_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mctw_pkg::*;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_item   i_item  = '0;
    logic    o_busy;
    logic    o_valid;
    t_result o_result;

    multi_channel_task_watchdog_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Model state: one countdown per channel plus the sticky trip flag.
    logic [COUNT_W-1:0] ticks_left [CHANNELS];
    logic               trip_flag;

    // Expected result beats, oldest first.
    t_result expected_results [$];

    int mismatches   = 0;
    int results_seen = 0;
    int kicks_sent   = 0;
    int ticks_sent   = 0;
    int gap_max      = 9;
    logic trip_seen  = 1'b0;

    // Clock: 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Seconds to ticks: truncating divide, saturated to the counter width.
    function automatic logic [COUNT_W-1:0] secs_to_ticks(input logic [15:0] secs);
        int q;
        q = int'(secs) / TICK_SECONDS;
        if (q > COUNT_MAX)
            q = COUNT_MAX;
        return COUNT_W'(q);
    endfunction

    // Advance the model by one beat and return the result it must produce.
    function automatic t_result watchdog_step(input t_item item);
        t_result r;
        logic    hit;
        int      first;
        int      ch;
        hit   = 1'b0;
        first = 0;
        ch    = int'(item.channel);
        if (!trip_flag) begin
            if (item.action == ACT_KICK) begin
                if (ch < CHANNELS)
                    ticks_left[ch] = secs_to_ticks(item.timeout_secs);
            end else begin
                // A counter at 1 or 0 expires; every counter still steps down,
                // clamped at zero.
                for (int i = 0; i < CHANNELS; i++) begin
                    if (ticks_left[i] <= 1) begin
                        if (!hit)
                            first = i;
                        hit = 1'b1;
                        ticks_left[i] = '0;
                    end else begin
                        ticks_left[i] = ticks_left[i] - 1'b1;
                    end
                end
                if (hit)
                    trip_flag = 1'b1;
            end
        end
        r.expired_now     = hit;
        r.expired_channel = hit ? 3'(first) : 3'd0;
        r.tripped         = trip_flag;
        r.channel_count   = (ch < CHANNELS) ? ticks_left[ch] : '0;
        return r;
    endfunction

    function automatic t_item make_item(input logic act, input int ch, input int secs);
        t_item it;
        it.action       = act;
        it.channel      = 3'(ch);
        it.timeout_secs = 16'(secs);
        return it;
    endfunction

    // Send one command beat. Idle a random number of cycles first, then hold
    // start until the block takes the beat. Start is left high on return so a
    // back-to-back beat never toggles it within one time step.
    task automatic send_beat(input t_item item);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= item;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected_results.push_back(watchdog_step(item));
        if (item.action == ACT_KICK)
            kicks_sent++;
        else
            ticks_sent++;
    endtask

    // Reload every channel that would expire on the next tick.
    task automatic refresh_low_channels();
        int secs;
        for (int i = 0; i < CHANNELS; i++) begin
            if (ticks_left[i] <= 1) begin
                secs = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 65535)
                                                   : $urandom_range(10, 60);
                send_beat(make_item(ACT_KICK, i, secs));
            end
        end
    endtask

    // Pick a timeout, weighted toward small values so ticks drain counters.
    function automatic int random_secs();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 20);
            1: return $urandom_range(0, 200);
            2: return $urandom_range(0, 65535);
            3: return ($urandom_range(0, 1) != 0) ? 65535 : 0;
            default: return $urandom_range(10, 40);
        endcase
    endfunction

    // Result checker: compare each strobed beat against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_result.tripped)
                trip_seen = 1'b1;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %p", o_result));
            end else begin
                want = expected_results.pop_front();
                if (o_result.expired_now !== want.expired_now)
                    report_mismatch($sformatf("expired_now got %b want %b",
                                    o_result.expired_now, want.expired_now));
                if (o_result.expired_channel !== want.expired_channel)
                    report_mismatch($sformatf("expired_channel got %0d want %0d",
                                    o_result.expired_channel, want.expired_channel));
                if (o_result.tripped !== want.tripped)
                    report_mismatch($sformatf("tripped got %b want %b",
                                    o_result.tripped, want.tripped));
                if (o_result.channel_count !== want.channel_count)
                    report_mismatch($sformatf("channel_count got %0d want %0d",
                                    o_result.channel_count, want.channel_count));
            end
        end
    end

    // Two ticks straight out of reset: counts step 3 -> 2 -> 1 without expiry.
    task automatic test_reset_counts();
        send_beat(make_item(ACT_TICK, 0, 'hFFFF));
        send_beat(make_item(ACT_TICK, 7, 0));
    endtask

    // Kick timeouts at the edges of the divide, then tick a counter from 2.
    task automatic test_kick_extremes();
        send_beat(make_item(ACT_KICK, 0, 0));          // zero seconds -> 0
        send_beat(make_item(ACT_KICK, 1, 4));          // just under one tick
        send_beat(make_item(ACT_KICK, 2, 5));          // exactly one tick
        send_beat(make_item(ACT_KICK, 3, 9));          // remainder dropped
        send_beat(make_item(ACT_KICK, 4, 10));         // two ticks
        send_beat(make_item(ACT_KICK, 5, 'hFFFF));     // largest timeout
        send_beat(make_item(ACT_KICK, 6, 'hAAAA));
        send_beat(make_item(ACT_KICK, 7, 'h5555));
        send_beat(make_item(ACT_KICK, 0, 'h8000));
        send_beat(make_item(ACT_KICK, 1, 'h7FFF));
        send_beat(make_item(ACT_KICK, 2, 14));
        send_beat(make_item(ACT_KICK, 3, 15));
        send_beat(make_item(ACT_TICK, 4, 0));          // 2 -> 1, no expiry
        refresh_low_channels();
    endtask

    // Random kicks and ticks in phases of no idling, short idling and long idling, until the
    // total number of beats sent reaches n_total. Keep every counter above 1
    // before each tick so the block never trips here.
    task automatic test_random_traffic(input int n_total);
        int n;
        n = 0;
        while (kicks_sent + ticks_sent < n_total) begin
            if (n % 100 == 0)
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 9;
                endcase
            if ($urandom_range(0, 9) < 4) begin
                refresh_low_channels();
                send_beat(make_item(ACT_TICK, $urandom_range(0, 7), $urandom_range(0, 65535)));
            end else begin
                send_beat(make_item(ACT_KICK, $urandom_range(0, 7), random_secs()));
            end
            n++;
        end
    endtask

    // Force one counter to 0 and a higher one to 1 (or the reverse), tick to
    // expire both, then confirm every later beat leaves the state frozen.
    task automatic test_expiry_and_freeze();
        int lo;
        int hi;
        int lo_secs;
        int hi_secs;
        gap_max = 9;
        refresh_low_channels();
        lo = $urandom_range(0, 6);
        hi = $urandom_range(lo + 1, 7);
        if ($urandom_range(0, 1) != 0) begin
            lo_secs = $urandom_range(0, 4);
            hi_secs = $urandom_range(5, 9);
        end else begin
            lo_secs = $urandom_range(5, 9);
            hi_secs = $urandom_range(0, 4);
        end
        send_beat(make_item(ACT_KICK, lo, lo_secs));
        send_beat(make_item(ACT_KICK, hi, hi_secs));
        send_beat(make_item(ACT_TICK, $urandom_range(0, 7), 0));
        // Frozen: kicks and ticks must change nothing.
        for (int i = 0; i < CHANNELS; i++)
            send_beat(make_item(ACT_KICK, i, $urandom_range(0, 65535)));
        for (int i = 0; i < 12; i++)
            send_beat(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                                random_secs()));
    endtask

    initial begin : main
        int drain;
        for (int i = 0; i < CHANNELS; i++)
            ticks_left[i] = secs_to_ticks(16'(START_SECONDS));
        trip_flag = 1'b0;

        // Hold reset, then release it at a clock edge.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_counts();
        test_kick_extremes();
        test_random_traffic(1270);
        test_expiry_and_freeze();

        // Drop start and drain the outstanding results.
        i_start <= 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < 200) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                            expected_results.size()));

        $display("Covered %0d kick and %0d tick beats, %0d result beats checked.",
                 kicks_sent, ticks_sent, results_seen);
        $display("Trip latch observed: %0d, then frozen-state beats; %0d mismatches.",
                 trip_seen, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
